/* rtl/mps_pkg.sv */
// ----------------------------------------------------------------------------
// mps_pkg
// shared constants, codes and control structs of the job scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package mps_pkg;

  localparam int MAX_JOBS = 16;
  localparam int ID_W     = 4;
  localparam int CNT_W    = 5;
  localparam int ETA_W    = 31;
  localparam int PROG_W   = 17;

  localparam logic [ETA_W-1:0]  ETA_LIMIT    = 31'h7FFF_FFFF;
  localparam logic [PROG_W-1:0] PROGRESS_ONE = 17'h1_0000;

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_UPDATE  = 2'd1;
  localparam logic [1:0] OP_PICK    = 2'd2;
  localparam logic [1:0] OP_CLEANUP = 2'd3;

  localparam logic [1:0] MODE_ISSUE    = 2'd0;
  localparam logic [1:0] MODE_RR       = 2'd1;
  localparam logic [1:0] MODE_ETA      = 2'd2;
  localparam logic [1:0] MODE_PROGRESS = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  typedef struct packed {
    logic single;
    logic start;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/mps_ifs.sv */
// ----------------------------------------------------------------------------
// mps channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface mps_req_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                op;
  logic [mps_pkg::ID_W-1:0]  job_id;
  logic                      work_pending;
  logic                      running;
  logic [mps_pkg::ETA_W-1:0] eta;
  logic [mps_pkg::PROG_W-1:0] progress;

  modport source (output valid, op, job_id, work_pending, running, eta, progress, input ready);
  modport sink   (input valid, op, job_id, work_pending, running, eta, progress, output ready);
endinterface

interface mps_rsp_if;
  logic                     valid;
  logic                     ready;
  logic [mps_pkg::ID_W-1:0] chosen_id;
  logic                     found;
  logic [1:0]               status;

  modport source (output valid, chosen_id, found, status, input ready);
  modport sink   (input valid, chosen_id, found, status, output ready);
endinterface

`default_nettype wire

/* rtl/mps_ctrl.sv */
// ----------------------------------------------------------------------------
// mps_ctrl
// operation sequencer and response valid tracking
// ----------------------------------------------------------------------------
`default_nettype none

module mps_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  input  wire logic [1:0]        op,
  input  wire logic              rsp_ready,
  input  wire mps_pkg::dp_stat_t stat,
  output mps_pkg::dp_cmd_t       cmd,
  output logic                   req_ready,
  output logic                   rsp_valid
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       rsp_valid_next;
  logic       accept;
  logic       rsp_free;
  logic       scan_op;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == S_IDLE) && rsp_free;
  assign accept    = req_valid && req_ready;
  assign scan_op   = (op == mps_pkg::OP_PICK) || (op == mps_pkg::OP_CLEANUP);

  always_comb begin
    cmd.single = accept && !scan_op;
    cmd.start  = accept && scan_op;
    cmd.step   = (state == S_SCAN) && !stat.done;
    cmd.finish = (state == S_RESULT) && rsp_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (cmd.start) state_next = S_SCAN;
      S_SCAN:   if (stat.done) state_next = S_RESULT;
      S_RESULT: if (rsp_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (cmd.single || cmd.finish) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |-> (state == S_IDLE))
    else $error("request accepted outside idle");

  a_scan_enter: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == S_SCAN))
    else $error("scan op did not start a scan");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!rsp_valid || rsp_ready))
    else $error("result loaded over a pending response");

  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish || cmd.single) |=> (rsp_valid && (state == S_IDLE || state == S_SCAN)))
    else $error("finished transaction without response");

endmodule

`default_nettype wire

/* rtl/mps_dp.sv */
// ----------------------------------------------------------------------------
// mps_dp
// job table, run list, scan datapath and response registers
// ----------------------------------------------------------------------------
`default_nettype none

module mps_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire mps_pkg::dp_cmd_t            cmd,
  output mps_pkg::dp_stat_t                stat,
  input  wire logic                        cfg_wr_en,
  input  wire logic [1:0]                  cfg_wr_data,
  input  wire logic [1:0]                  op,
  input  wire logic [mps_pkg::ID_W-1:0]    job_id,
  input  wire logic                        work_pending,
  input  wire logic                        running,
  input  wire logic [mps_pkg::ETA_W-1:0]   eta,
  input  wire logic [mps_pkg::PROG_W-1:0]  progress,
  output logic [mps_pkg::ID_W-1:0]         chosen_id,
  output logic                             found,
  output logic [1:0]                       status
);

  logic [mps_pkg::ID_W-1:0]   run_order [mps_pkg::MAX_JOBS];
  logic                       work_flags [mps_pkg::MAX_JOBS];
  logic                       running_flags [mps_pkg::MAX_JOBS];
  logic [mps_pkg::ETA_W-1:0]  eta_table [mps_pkg::MAX_JOBS];
  logic [mps_pkg::PROG_W-1:0] progress_table [mps_pkg::MAX_JOBS];

  logic [mps_pkg::CNT_W-1:0]  run_count;
  logic [mps_pkg::CNT_W-1:0]  jobs_added;
  logic [1:0]                 schedule_mode;

  logic                       scan_pick;
  logic [mps_pkg::CNT_W-1:0]  idx;
  logic [mps_pkg::CNT_W-1:0]  kept;
  logic [mps_pkg::ETA_W-1:0]  best;
  logic [mps_pkg::ID_W-1:0]   pick_id;
  logic                       got;
  logic                       stop;

  logic [mps_pkg::ID_W-1:0]   cur_id;
  logic                       cur_work;
  logic                       cur_run;
  logic [mps_pkg::ETA_W-1:0]  cur_val;
  logic                       is_add;
  logic                       add_ok;
  logic                       upd_ok;
  logic                       rotate;
  logic                       hit;
  logic                       better;

  assign is_add = (op == mps_pkg::OP_ADD);
  assign add_ok = (jobs_added < mps_pkg::CNT_W'(mps_pkg::MAX_JOBS))
               && (run_count < mps_pkg::CNT_W'(mps_pkg::MAX_JOBS));
  assign upd_ok = ({1'b0, job_id} < jobs_added);

  assign rotate = scan_pick && (schedule_mode == mps_pkg::MODE_RR);
  assign cur_id = rotate ? run_order[0] : run_order[idx[mps_pkg::ID_W-1:0]];
  assign cur_work = work_flags[cur_id];
  assign cur_run  = running_flags[cur_id];
  assign cur_val  = (schedule_mode == mps_pkg::MODE_ETA) ? eta_table[cur_id]
                  : mps_pkg::ETA_W'(progress_table[cur_id]);
  assign hit      = cur_work && ((schedule_mode == mps_pkg::MODE_ISSUE) || rotate);
  assign better   = cur_work && (cur_val < best);

  assign stat.done = stop || (idx == run_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      schedule_mode <= mps_pkg::MODE_ISSUE;
    end else if (cfg_wr_en) begin
      schedule_mode <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count  <= '0;
      jobs_added <= '0;
    end else if (cmd.single && is_add && add_ok) begin
      run_count  <= run_count + 1'b1;
      jobs_added <= jobs_added + 1'b1;
    end else if (cmd.finish && !scan_pick) begin
      run_count <= kept;
    end
  end

  // slot table
  always_ff @(posedge clk) begin
    if (cmd.single && is_add && add_ok) begin
      work_flags[jobs_added[mps_pkg::ID_W-1:0]]     <= 1'b0;
      running_flags[jobs_added[mps_pkg::ID_W-1:0]]  <= 1'b0;
      eta_table[jobs_added[mps_pkg::ID_W-1:0]]      <= '0;
      progress_table[jobs_added[mps_pkg::ID_W-1:0]] <= '0;
    end else if (cmd.single && !is_add && upd_ok) begin
      work_flags[job_id]     <= work_pending;
      running_flags[job_id]  <= running;
      eta_table[job_id]      <= eta;
      progress_table[job_id] <= progress;
    end
  end

  // run list
  always_ff @(posedge clk) begin
    if (cmd.single && is_add && add_ok) begin
      run_order[run_count[mps_pkg::ID_W-1:0]] <= jobs_added[mps_pkg::ID_W-1:0];
    end else if (cmd.step && rotate) begin
      for (int j = 0; j < mps_pkg::MAX_JOBS; j++) begin
        if (mps_pkg::CNT_W'(j + 1) < run_count) begin
          run_order[j] <= run_order[j + 1 < mps_pkg::MAX_JOBS ? j + 1 : j];
        end else if (mps_pkg::CNT_W'(j + 1) == run_count) begin
          run_order[j] <= run_order[0];
        end
      end
    end else if (cmd.step && !scan_pick && cur_run) begin
      run_order[kept[mps_pkg::ID_W-1:0]] <= cur_id;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      scan_pick <= (op == mps_pkg::OP_PICK);
      idx       <= '0;
      kept      <= '0;
      got       <= 1'b0;
      stop      <= 1'b0;
      best      <= (schedule_mode == mps_pkg::MODE_ETA) ? mps_pkg::ETA_LIMIT
                 : mps_pkg::ETA_W'(mps_pkg::PROGRESS_ONE);
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
      if (scan_pick) begin
        unique case (schedule_mode)
          mps_pkg::MODE_ISSUE, mps_pkg::MODE_RR: begin
            if (hit) begin
              pick_id <= cur_id;
              got     <= 1'b1;
              stop    <= 1'b1;
            end
          end
          mps_pkg::MODE_ETA, mps_pkg::MODE_PROGRESS: begin
            if (better) begin
              best    <= cur_val;
              pick_id <= cur_id;
              got     <= 1'b1;
            end
          end
          default: ;
        endcase
      end else if (cur_run) begin
        kept <= kept + 1'b1;
      end
    end
  end

  // response registers
  always_ff @(posedge clk) begin
    if (cmd.single) begin
      if (is_add) begin
        chosen_id <= add_ok ? jobs_added[mps_pkg::ID_W-1:0] : '0;
        found     <= add_ok;
        status    <= add_ok ? mps_pkg::ST_OK : mps_pkg::ST_FULL;
      end else begin
        chosen_id <= '0;
        found     <= 1'b0;
        status    <= upd_ok ? mps_pkg::ST_OK : mps_pkg::ST_UNKNOWN;
      end
    end else if (cmd.finish) begin
      chosen_id <= (scan_pick && got) ? pick_id : '0;
      found     <= scan_pick && got;
      status    <= mps_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

/* rtl/multi_policy_job_scheduler.sv */
// ----------------------------------------------------------------------------
// multi_policy_job_scheduler
// run list of up to MAX_JOBS job slots with add, update, pick and cleanup
//
// req carries one operation per transaction (op, job_id, work_pending,
// running, eta and progress fields), rsp returns one result per operation
// (chosen_id, found, status). The pick policy comes from the schedule_mode
// register, written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, the block itself does not enforce this.
// Add and update complete in the accept cycle: the response is valid on the
// next cycle and the next request can follow right behind it. Pick and
// cleanup walk the run list one entry per cycle through the single scan
// datapath, stopping early when issue order or round robin hits, and the
// result is loaded once the response register is empty or being drained.
// The next request is taken once the block is idle and the response register
// is empty or being drained. A stalled receiver holds the response and
// blocks further requests. Reset empties the run list, zeroes the job count,
// selects issue order and drops any pending response.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_policy_job_scheduler (
  input  wire logic       clk,
  input  wire logic       rst,
  mps_req_if.sink         req,
  mps_rsp_if.source       rsp,
  input  wire logic       cfg_wr_en,
  input  wire logic [1:0] cfg_wr_data
);

  mps_pkg::dp_cmd_t  cmd;
  mps_pkg::dp_stat_t stat;

  mps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .op        (req.op),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid)
  );

  mps_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .op           (req.op),
    .job_id       (req.job_id),
    .work_pending (req.work_pending),
    .running      (req.running),
    .eta          (req.eta),
    .progress     (req.progress),
    .chosen_id    (rsp.chosen_id),
    .found        (rsp.found),
    .status       (rsp.status)
  );

endmodule

`default_nettype wire

/* bench/tb_multi_policy_job_scheduler.sv */
// ----------------------------------------------------------------------------
// tb_multi_policy_job_scheduler
// self-checking bench for the job scheduler: queued add, update, pick and
// cleanup transactions with random gaps and response stalls, every response
// checked against a cycle-free scheduler model kept in the bench, across all
// four pick policies
// ----------------------------------------------------------------------------
module tb_multi_policy_job_scheduler;

  localparam int CLK_HALF      = 5;
  localparam int SETTLE_CYCLES = mps_pkg::MAX_JOBS + 2;
  localparam int PHASES        = 8;
  localparam int PHASE_OPS     = 225;
  localparam int IDLE_PCT      = 19;
  localparam int CALM_PHASE    = 3;

  typedef struct packed {
    logic [1:0]                 op;
    logic [mps_pkg::ID_W-1:0]   job_id;
    logic                       work_pending;
    logic                       running;
    logic [mps_pkg::ETA_W-1:0]  eta;
    logic [mps_pkg::PROG_W-1:0] progress;
  } sched_op_t;

  typedef struct packed {
    logic [mps_pkg::ID_W-1:0] chosen_id;
    logic                     found;
    logic [1:0]               status;
  } sched_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_wr_en;
  logic [1:0] cfg_wr_data;

  mps_req_if req_ch();
  mps_rsp_if rsp_ch();

  multi_policy_job_scheduler DUT (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // scheduler model state
  logic [1:0]                 sched_mode = mps_pkg::MODE_ISSUE;
  logic [mps_pkg::ID_W-1:0]   list_ids [mps_pkg::MAX_JOBS];
  logic [mps_pkg::CNT_W-1:0]  list_len = '0;
  logic [mps_pkg::CNT_W-1:0]  next_job = '0;
  logic                       slot_work [mps_pkg::MAX_JOBS];
  logic                       slot_running [mps_pkg::MAX_JOBS];
  logic [mps_pkg::ETA_W-1:0]  slot_eta [mps_pkg::MAX_JOBS];
  logic [mps_pkg::PROG_W-1:0] slot_prog [mps_pkg::MAX_JOBS];

  sched_op_t     op_queue [$];
  sched_result_t pending_results [$];
  sched_op_t     in_flight;
  int            queued_total   = 0;
  int            accepted_total = 0;
  int            mismatch_count = 0;
  logic          gaps_on        = 1'b1;

  function automatic sched_result_t schedule_result(sched_op_t t);
    sched_result_t            res;
    logic [mps_pkg::ID_W-1:0] head;
    logic [mps_pkg::ID_W-1:0] id;
    logic [31:0]              best;
    logic [31:0]              val;
    logic                     hit;
    int                       n;
    int                       kept;
    res  = '0;
    hit  = 1'b0;
    kept = 0;
    n    = list_len;
    case (t.op)
      mps_pkg::OP_ADD: begin
        if (next_job < mps_pkg::MAX_JOBS && list_len < mps_pkg::MAX_JOBS) begin
          id = next_job[mps_pkg::ID_W-1:0];
          slot_work[id]    = 1'b0;
          slot_running[id] = 1'b0;
          slot_eta[id]     = '0;
          slot_prog[id]    = '0;
          list_ids[n]      = id;
          list_len         = list_len + 1'b1;
          next_job         = next_job + 1'b1;
          res.chosen_id    = id;
          res.found        = 1'b1;
        end else begin
          res.status = mps_pkg::ST_FULL;
        end
      end
      mps_pkg::OP_UPDATE: begin
        if (t.job_id < next_job) begin
          slot_work[t.job_id]    = t.work_pending;
          slot_running[t.job_id] = t.running;
          slot_eta[t.job_id]     = t.eta;
          slot_prog[t.job_id]    = t.progress;
        end else begin
          res.status = mps_pkg::ST_UNKNOWN;
        end
      end
      mps_pkg::OP_PICK: begin
        if (sched_mode == mps_pkg::MODE_ISSUE) begin
          for (int i = 0; i < n && !hit; i++) begin
            if (slot_work[list_ids[i]]) begin
              hit           = 1'b1;
              res.chosen_id = list_ids[i];
            end
          end
        end else if (sched_mode == mps_pkg::MODE_RR) begin
          for (int i = 0; i < n && !hit; i++) begin
            head = list_ids[0];
            for (int j = 0; j < n - 1; j++) list_ids[j] = list_ids[j + 1];
            list_ids[n - 1] = head;
            if (slot_work[head]) begin
              hit           = 1'b1;
              res.chosen_id = head;
            end
          end
        end else begin
          best = (sched_mode == mps_pkg::MODE_ETA) ? 32'(mps_pkg::ETA_LIMIT)
               : 32'(mps_pkg::PROGRESS_ONE);
          for (int i = 0; i < n; i++) begin
            id = list_ids[i];
            if (slot_work[id]) begin
              val = (sched_mode == mps_pkg::MODE_ETA) ? 32'(slot_eta[id])
                  : 32'(slot_prog[id]);
              if (val < best) begin
                best          = val;
                res.chosen_id = id;
                hit           = 1'b1;
              end
            end
          end
        end
        res.found = hit;
      end
      default: begin
        for (int i = 0; i < n; i++) begin
          if (slot_running[list_ids[i]]) begin
            list_ids[kept] = list_ids[i];
            kept++;
          end
        end
        list_len = mps_pkg::CNT_W'(kept);
      end
    endcase
    return res;
  endfunction

  function automatic sched_op_t make_op(logic [1:0] op, logic [mps_pkg::ID_W-1:0] job_id,
                                        logic work_pending, logic running,
                                        logic [mps_pkg::ETA_W-1:0] eta,
                                        logic [mps_pkg::PROG_W-1:0] progress);
    sched_op_t t;
    t.op           = op;
    t.job_id       = job_id;
    t.work_pending = work_pending;
    t.running      = running;
    t.eta          = eta;
    t.progress     = progress;
    return t;
  endfunction

  function automatic sched_op_t random_op(logic [1:0] op, logic [mps_pkg::ID_W-1:0] job_id,
                                          int hw_pct);
    logic [mps_pkg::ETA_W-1:0]  eta;
    logic [mps_pkg::PROG_W-1:0] prog;
    case ($urandom_range(0, 5))
      0:       eta = '0;
      1:       eta = mps_pkg::ETA_LIMIT;
      2:       eta = mps_pkg::ETA_LIMIT - 1'b1;
      3:       eta = mps_pkg::ETA_W'($urandom_range(0, 7));
      default: eta = mps_pkg::ETA_W'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0:       prog = '0;
      1:       prog = mps_pkg::PROGRESS_ONE;
      2:       prog = mps_pkg::PROGRESS_ONE - 1'b1;
      3:       prog = mps_pkg::PROG_W'($urandom_range(0, 7));
      4:       prog = mps_pkg::PROG_W'($urandom_range(0, 65535));
      default: prog = mps_pkg::PROG_W'($urandom_range(65537, 131071));
    endcase
    return make_op(op, job_id, $urandom_range(0, 99) < hw_pct,
                   $urandom_range(0, 99) >= 2, eta, prog);
  endfunction

  task automatic push_op(sched_op_t t);
    op_queue = {op_queue, t};
    queued_total++;
  endtask

  task automatic write_mode(logic [1:0] m);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    sched_mode   = m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic wait_idle();
    while (accepted_total != queued_total || pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        pending_results = {pending_results, schedule_result(in_flight)};
        accepted_total++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (op_queue.size() > 0 && !(gaps_on && $urandom_range(0, 99) < IDLE_PCT)) begin
          in_flight = op_queue[0];
          op_queue.delete(0);
          req_ch.valid        <= 1'b1;
          req_ch.op           <= in_flight.op;
          req_ch.job_id       <= in_flight.job_id;
          req_ch.work_pending <= in_flight.work_pending;
          req_ch.running      <= in_flight.running;
          req_ch.eta          <= in_flight.eta;
          req_ch.progress     <= in_flight.progress;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    sched_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("response with no transaction pending: chosen_id %0d found %0d status %0d",
                 rsp_ch.chosen_id, rsp_ch.found, rsp_ch.status);
          mismatch_count++;
        end else begin
          want = pending_results[0];
          pending_results.delete(0);
          if (rsp_ch.chosen_id !== want.chosen_id) begin
            $error("chosen_id: expected %0d, got %0d", want.chosen_id, rsp_ch.chosen_id);
            mismatch_count++;
          end
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            mismatch_count++;
          end
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
            mismatch_count++;
          end
        end
      end
      rsp_ch.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    logic [1:0] phase_modes [PHASES];
    logic [1:0] roll_op;
    int         hw_pct;
    int         roll;
    phase_modes = '{mps_pkg::MODE_RR, mps_pkg::MODE_ETA, mps_pkg::MODE_PROGRESS,
                    mps_pkg::MODE_ISSUE, mps_pkg::MODE_PROGRESS, mps_pkg::MODE_ETA,
                    mps_pkg::MODE_RR, mps_pkg::MODE_ISSUE};
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= mps_pkg::MODE_ISSUE;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    write_mode(mps_pkg::MODE_ISSUE);

    // empty table: pick and cleanup on an empty list, updates of unknown jobs
    push_op(make_op(mps_pkg::OP_PICK, '0, 1'b0, 1'b0, '0, '0));
    push_op(make_op(mps_pkg::OP_CLEANUP, '0, 1'b0, 1'b0, '0, '0));
    push_op(make_op(mps_pkg::OP_UPDATE, '1, 1'b1, 1'b1, '1, '1));
    push_op(make_op(mps_pkg::OP_UPDATE, '0, 1'b0, 1'b0, '0, '0));
    for (int i = 0; i < mps_pkg::MAX_JOBS; i++) begin
      push_op(make_op(mps_pkg::OP_ADD, '1, 1'b1, 1'b1, '1, '1));
    end
    // table full
    push_op(make_op(mps_pkg::OP_ADD, '0, 1'b0, 1'b0, '0, '0));
    push_op(make_op(mps_pkg::OP_PICK, '0, 1'b0, 1'b0, '0, '0));
    push_op(make_op(mps_pkg::OP_UPDATE, '1, 1'b1, 1'b1, '0, '0));
    push_op(make_op(mps_pkg::OP_UPDATE, '0, 1'b1, 1'b1, mps_pkg::ETA_LIMIT,
                    mps_pkg::PROGRESS_ONE));
    push_op(make_op(mps_pkg::OP_PICK, '1, 1'b1, 1'b1, '1, '1));
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      write_mode(p == PHASES - 1 ? 2'($urandom_range(0, 3)) : phase_modes[p]);
      gaps_on = (p != CALM_PHASE);
      hw_pct  = (p % 3 == 2) ? 25 : 70;
      // refresh every slot so that cleanup keeps most of the list
      for (int i = 0; i < mps_pkg::MAX_JOBS; i++) begin
        push_op(random_op(mps_pkg::OP_UPDATE, mps_pkg::ID_W'(i), hw_pct));
      end
      repeat (PHASE_OPS - mps_pkg::MAX_JOBS) begin
        roll = $urandom_range(0, 199);
        if (roll < 8) roll_op = mps_pkg::OP_ADD;
        else if (roll < 100) roll_op = mps_pkg::OP_UPDATE;
        else if (roll < 197) roll_op = mps_pkg::OP_PICK;
        else roll_op = mps_pkg::OP_CLEANUP;
        push_op(random_op(roll_op, mps_pkg::ID_W'($urandom_range(0, mps_pkg::MAX_JOBS - 1)),
                          hw_pct));
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
